FILE: hw/rtl/amc_pkg.sv
// Package: element counts, codes and float helpers for the 3x4 affine concat block.
package amc_pkg;

    localparam int unsigned NumElems = 12;
    localparam int unsigned NumRows  = 3;
    localparam int unsigned NumCols  = 4;
    localparam int unsigned IdxW     = 4;

    localparam logic [1:0] ModeLoadL   = 2'd0;
    localparam logic [1:0] ModeLoadR   = 2'd1;
    localparam logic [1:0] ModeCompute = 2'd2;

    localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
    localparam logic [31:0] QuietBit   = 32'h0040_0000;

    function automatic logic f_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic f_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

endpackage

FILE: hw/rtl/amc_ram.sv
// Generic single-port-write RAM with registered read.
module amc_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/affine_matrix_concat_3x4_top.sv
// Top level: element stores, sequencer and shared multiply/add unit.
//
// channel | dir | handshake          | payload
// in      | in  | i_valid / o_stall  | i_mode, i_element_index, i_element_bits
// out     | out | o_valid / i_stall  | o_result_index, o_result_bits, o_last_flag
//
// A load with an index below 12 is written into its element store when accepted. A
// compute runs 12 elements on one shared float unit; each operation passes through the
// states OPA, EXEC, X1, X2 and X3, after RD and RDW for an element RAM read where one
// is needed, and each element ends in the output state OUT. The input stays stalled
// through a compute, and longer while the output is stalled. Reset is synchronous,
// active low, and clears control only; element stores hold garbage until loaded.
module affine_matrix_concat_3x4_top
    import amc_pkg::IdxW;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_mode,
    input  logic [IdxW-1:0] i_element_index,
    input  logic [31:0]     i_element_bits,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [IdxW-1:0] o_result_index,
    output logic [31:0]     o_result_bits,
    output logic            o_last_flag
);
    import amc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_OPA, S_OPB, S_EXEC, S_X1, S_X2, S_X3, S_OUT
    } t_state;

    // micro-op step within an element:
    // 0: p=L0*R0  1: t=L1*R1  2: p=p+t  3: t=L2*R2  4: p=p+t  5: p=p+L3
    t_state          r_state;
    logic [2:0]      r_step;
    logic [1:0]      r_row, r_col;
    logic [IdxW-1:0] r_k;
    logic [31:0]     r_p, r_t, r_a, r_b;
    logic            r_isadd;
    logic            r_valid;
    logic [IdxW-1:0] r_oidx;
    logic [31:0]     r_obits;
    logic            r_olast;

    logic            in_acc;
    logic [IdxW-1:0] l_ra, r_ra;
    logic [31:0]     l_rd, r_rd;

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        l_ra = IdxW'({r_row, 2'b00});
        r_ra = IdxW'({2'b00, r_col});
        case (r_step)
            3'd1: begin
                l_ra = IdxW'({r_row, 2'b01});
                r_ra = IdxW'({2'b01, r_col});
            end
            3'd3: begin
                l_ra = IdxW'({r_row, 2'b10});
                r_ra = IdxW'({2'b10, r_col});
            end
            3'd5: l_ra = IdxW'({r_row, 2'b11});
            default: ;
        endcase
    end

    amc_ram #(.Width(32), .Depth(NumElems)) u_left (
        .i_clk, .i_we(in_acc && i_mode == ModeLoadL && i_element_index < IdxW'(NumElems)),
        .i_waddr(i_element_index), .i_wdata(i_element_bits),
        .i_raddr(l_ra), .o_rdata(l_rd)
    );
    amc_ram #(.Width(32), .Depth(NumElems)) u_right (
        .i_clk, .i_we(in_acc && i_mode == ModeLoadR && i_element_index < IdxW'(NumElems)),
        .i_waddr(i_element_index), .i_wdata(i_element_bits),
        .i_raddr(r_ra), .o_rdata(r_rd)
    );

    // ---------------- shared float unit, multi-cycle ----------------
    logic [31:0] r_fres;   // special-case or final result
    logic        r_fspec;
    logic        r_sign;
    logic signed [10:0] r_e;
    logic [63:0] r_s;      // significand, bit 62 lead after normalize
    logic [5:0]  r_nrm;    // leading-zero count of r_s

    // stage EXEC: specials, unpack, multiply or align/add
    logic [31:0] fa, fb;
    logic [7:0]  ea8, eb8;
    logic [23:0] ma, mb;
    logic [4:0]  lza, lzb;
    logic [23:0] na, nb;
    logic signed [10:0] xea, xeb;
    logic [47:0] prod;
    logic [31:0] spec;
    logic        isspec;
    logic [63:0] ga, gb, gsh, gsum;
    logic [7:0]  dexp;
    logic        swp, sa, sb, ssum;
    logic signed [10:0] ebig;

    function automatic logic [4:0] f_lz24(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 23; i >= 0; i--) begin
            if (m[i]) begin
                n = 5'(23 - i);
                break;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] f_lz63(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd63;
        for (int i = 62; i >= 0; i--) begin
            if (v[i]) begin
                n = 6'(62 - i);
                break;
            end
        end
        return n;
    endfunction

    always_comb begin
        fa  = r_a;
        fb  = r_b;
        ea8 = fa[30:23];
        eb8 = fb[30:23];
        ma  = {ea8 != 8'd0, fa[22:0]};
        mb  = {eb8 != 8'd0, fb[22:0]};
        lza = f_lz24(ma);
        lzb = f_lz24(mb);
        na  = ma << lza;
        nb  = mb << lzb;
        xea = (ea8 == 8'd0) ? 11'sd1 - 11'(lza) : 11'($signed({3'b000, ea8}));
        xeb = (eb8 == 8'd0) ? 11'sd1 - 11'(lzb) : 11'($signed({3'b000, eb8}));
        prod = na * nb;
        isspec = 1'b1;
        spec = 32'd0;
        if (f_is_nan(fa)) begin
            spec = fa | QuietBit;
        end else if (f_is_nan(fb)) begin
            spec = fb | QuietBit;
        end else if (!r_isadd) begin
            if (f_is_inf(fa) || f_is_inf(fb)) begin
                spec = (f_is_zero(fa) || f_is_zero(fb)) ? DefaultNan
                     : {fa[31] ^ fb[31], 31'h7F80_0000};
            end else if (f_is_zero(fa) || f_is_zero(fb)) begin
                spec = {fa[31] ^ fb[31], 31'd0};
            end else begin
                isspec = 1'b0;
            end
        end else begin
            if (f_is_inf(fa)) begin
                spec = (f_is_inf(fb) && fa[31] != fb[31]) ? DefaultNan : fa;
            end else if (f_is_inf(fb)) begin
                spec = fb;
            end else if (f_is_zero(fa) && f_is_zero(fb)) begin
                spec = {fa[31] & fb[31], 31'd0};
            end else if (f_is_zero(fa)) begin
                spec = fb;
            end else if (f_is_zero(fb)) begin
                spec = fa;
            end else begin
                isspec = 1'b0;
            end
        end
        // adder path, unnormalized subnormals as in IEEE add
        swp  = (ea8 == 8'd0 ? 8'd1 : ea8) < (eb8 == 8'd0 ? 8'd1 : eb8);
        ga   = swp ? {2'b0, mb, 38'd0} : {2'b0, ma, 38'd0};
        gb   = swp ? {2'b0, ma, 38'd0} : {2'b0, mb, 38'd0};
        sa   = swp ? fb[31] : fa[31];
        sb   = swp ? fa[31] : fb[31];
        ebig = swp ? 11'($signed({3'b000, (eb8 == 8'd0 ? 8'd1 : eb8)}))
                   : 11'($signed({3'b000, (ea8 == 8'd0 ? 8'd1 : ea8)}));
        dexp = swp ? (eb8 == 8'd0 ? 8'd1 : eb8) - (ea8 == 8'd0 ? 8'd1 : ea8)
                   : (ea8 == 8'd0 ? 8'd1 : ea8) - (eb8 == 8'd0 ? 8'd1 : eb8);
        if (dexp >= 8'd63) begin
            gsh = {63'd0, gb != 64'd0};
        end else begin
            gsh = (gb >> dexp) | {63'd0, (gb & ((64'd1 << dexp) - 64'd1)) != 64'd0};
        end
        if (sa == sb) begin
            gsum = ga + gsh;
            ssum = sa;
        end else if (ga >= gsh) begin
            gsum = ga - gsh;
            ssum = sa;
        end else begin
            gsum = gsh - ga;
            ssum = sb;
        end
    end

    // stage X1 -> leading-zero count, X2 -> normalize and round
    logic [63:0] nsig;
    logic signed [10:0] ne;
    logic [63:0] rsig;
    logic [23:0] rm;
    logic [38:0] rem;
    logic [31:0] rbits;
    logic [24:0] rm1;
    logic [8:0]  sh;

    always_comb begin
        nsig = r_s << r_nrm;
        ne   = r_e - 11'(r_nrm);
        rsig = nsig;
        if (ne < 11'sd1) begin
            sh = (11'sd1 - ne > 11'sd63) ? 9'd63 : 9'(11'sd1 - ne);
            if (sh >= 9'd63) begin
                rsig = {63'd0, nsig != 64'd0};
            end else begin
                rsig = (nsig >> sh) | {63'd0, (nsig & ((64'd1 << sh) - 64'd1)) != 64'd0};
            end
        end else begin
            sh = 9'd0;
        end
        rm  = rsig[62:39];
        rem = rsig[38:0];
        rm1 = {1'b0, rm};
        if (rem > 39'h40_0000_0000 || (rem == 39'h40_0000_0000 && rm[0])) begin
            rm1 = rm1 + 25'd1;
        end
        rbits = ({21'd0, ((ne < 11'sd1) ? 11'd0 : 11'(ne - 11'sd1))} << 23)
              + {7'd0, rm1};
        if (ne >= 11'sd255 || rbits >= 32'h7F80_0000) begin
            rbits = 32'h7F80_0000;
        end
        rbits[31] = r_sign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            if (r_state == S_OUT && (!r_valid || !i_stall)) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_mode == ModeCompute) begin
                        r_row   <= 2'd0;
                        r_col   <= 2'd0;
                        r_k     <= '0;
                        r_step  <= 3'd0;
                        r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: r_state <= S_OPA;
                S_OPA: begin
                    r_isadd <= (r_step == 3'd2) || (r_step == 3'd4) || (r_step == 3'd5);
                    case (r_step)
                        3'd2, 3'd4: begin
                            r_a <= r_p;
                            r_b <= r_t;
                        end
                        3'd5: begin
                            r_a <= r_p;
                            r_b <= l_rd;
                        end
                        default: begin
                            r_a <= l_rd;
                            r_b <= r_rd;
                        end
                    endcase
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_fspec <= isspec;
                    r_fres  <= spec;
                    if (r_isadd) begin
                        r_sign <= ssum;
                        r_e    <= ebig + 11'sd1;
                        r_s    <= gsum;
                    end else begin
                        r_sign <= fa[31] ^ fb[31];
                        r_e    <= xea + xeb - 11'sd126;
                        r_s    <= {1'b0, prod, 15'd0};
                    end
                    r_state <= S_X1;
                end
                S_X1: begin
                    r_nrm   <= f_lz63(r_s);
                    r_state <= S_X2;
                end
                S_X2: begin
                    if (!r_fspec) begin
                        r_fres <= (r_s == 64'd0) ? 32'd0 : rbits;
                    end
                    r_state <= S_X3;
                end
                S_X3: begin
                    case (r_step)
                        3'd1, 3'd3: r_t <= r_fres;
                        default:    r_p <= r_fres;
                    endcase
                    if (r_step == 3'd5 || (r_step == 3'd4 && r_col != 2'd3)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step  <= r_step + 3'd1;
                        r_state <= (r_step == 3'd1 || r_step == 3'd3) ? S_OPA : S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall) begin
                        r_oidx  <= r_k;
                        r_obits <= r_p;
                        r_olast <= r_k == IdxW'(NumElems - 1);
                        r_step  <= 3'd0;
                        if (r_k == IdxW'(NumElems - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + IdxW'(1);
                            if (r_col == 2'(NumCols - 1)) begin
                                r_col <= 2'd0;
                                r_row <= r_row + 2'd1;
                            end else begin
                                r_col <= r_col + 2'd1;
                            end
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_result_index = r_oidx;
    assign o_result_bits  = r_obits;
    assign o_last_flag    = r_olast;
endmodule

FILE: hw/rtl/amc_checker.sv
// Port-level checker for the affine concat top level, with its bind.
module amc_checker
    import amc_pkg::IdxW;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [IdxW-1:0] o_result_index,
    input logic [31:0]     o_result_bits,
    input logic            o_last_flag
);
    import amc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_bits) && $stable(o_result_index))
        else $error("stalled result changed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_flag == (o_result_index == IdxW'(NumElems - 1))))
        else $error("last flag mismatch");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_flag |-> o_stall)
        else $error("input open during a compute run");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_index < IdxW'(NumElems))
        else $error("result index out of range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind affine_matrix_concat_3x4_top amc_checker u_amc_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall,
    .o_result_index, .o_result_bits, .o_last_flag
);

FILE: verif/affine_matrix_concat_3x4_top_tb.sv
// Testbench for the 3x4 affine concat block: element loads, computes, float predictor.
module affine_matrix_concat_3x4_top_tb;
    import amc_pkg::*;

    typedef struct packed {
        logic [1:0]      mode;
        logic [IdxW-1:0] idx;
        logic [31:0]     bits;
    } t_load_item;

    typedef struct packed {
        logic [IdxW-1:0] idx;
        logic [31:0]     bits;
        logic            last;
    } t_product;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [1:0]      i_mode;
    logic [IdxW-1:0] i_element_index;
    logic [31:0]     i_element_bits;
    logic            o_valid;
    logic            i_stall;
    logic [IdxW-1:0] o_result_index;
    logic [31:0]     o_result_bits;
    logic            o_last_flag;

    affine_matrix_concat_3x4_top u_dut (.*);

    t_load_item  pending_items[$];
    t_product    expected_products[$];
    logic [31:0] left_mtx[NumElems];
    logic [31:0] right_mtx[NumElems];
    int          mismatches;
    int          send_gap;
    int          recv_gap;
    int          hold_off;
    bit          quiet_tail;
    bit          hold_req;
    bit          drive_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic fp_nan(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic logic fp_inf(logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic fp_zero(logic [31:0] x);
        return x[30:0] == 0;
    endfunction

    function automatic logic [63:0] sticky_shr(logic [63:0] s, int n);
        if (n >= 63) return {63'd0, s != 0};
        return (s >> n) | {63'd0, (s & ((64'd1 << n) - 1)) != 0};
    endfunction

    function automatic logic [31:0] round_rne(logic [31:0] sign, int e, logic [63:0] sig);
        logic [63:0] rem;
        logic [31:0] m;
        logic [31:0] r;
        if (e >= 255) return sign | 32'h7F80_0000;
        if (e < 1) begin
            sig = sticky_shr(sig, 1 - e);
            e = 1;
        end
        m = 32'(sig[63:39]);
        rem = sig & ((64'd1 << 39) - 1);
        if (rem > (64'd1 << 38) || (rem == (64'd1 << 38) && m[0])) m = m + 1;
        r = ((e - 1) << 23) + m;
        if (r >= 32'h7F80_0000) r = 32'h7F80_0000;
        return sign | r;
    endfunction

    function automatic logic [31:0] norm_sig(logic [31:0] x, output int e);
        int ex;
        logic [31:0] m;
        ex = x[30:23];
        m = {9'd0, x[22:0]};
        if (ex == 0) begin
            ex = 1;
            while (!m[23]) begin
                m = m << 1;
                ex--;
            end
        end else begin
            m[23] = 1'b1;
        end
        e = ex;
        return m;
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic [31:0] sign;
        logic [63:0] p;
        int ea, eb;
        sign = (a ^ b) & 32'h8000_0000;
        if (fp_nan(a)) return a | QuietBit;
        if (fp_nan(b)) return b | QuietBit;
        if (fp_inf(a) || fp_inf(b)) begin
            if (fp_zero(a) || fp_zero(b)) return DefaultNan;
            return sign | 32'h7F80_0000;
        end
        if (fp_zero(a) || fp_zero(b)) return sign;
        p = {32'd0, norm_sig(a, ea)} * {32'd0, norm_sig(b, eb)};
        if (p[47]) return round_rne(sign, ea + eb - 126, p << 15);
        return round_rne(sign, ea + eb - 127, p << 16);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] sa, sb, sign, t;
        logic [63:0] ga, gb, s;
        int ea, eb, e;
        sa = a & 32'h8000_0000;
        sb = b & 32'h8000_0000;
        if (fp_nan(a)) return a | QuietBit;
        if (fp_nan(b)) return b | QuietBit;
        if (fp_inf(a)) begin
            if (fp_inf(b) && sa != sb) return DefaultNan;
            return a;
        end
        if (fp_inf(b)) return b;
        if (fp_zero(a) && fp_zero(b)) return sa & sb;
        if (fp_zero(a)) return b;
        if (fp_zero(b)) return a;
        ea = a[30:23];
        eb = b[30:23];
        ga = {41'd0, a[22:0]};
        gb = {41'd0, b[22:0]};
        if (ea == 0) ea = 1; else ga[23] = 1'b1;
        if (eb == 0) eb = 1; else gb[23] = 1'b1;
        ga = ga << 38;
        gb = gb << 38;
        if (ea < eb) begin
            e = ea; ea = eb; eb = e;
            s = ga; ga = gb; gb = s;
            t = sa; sa = sb; sb = t;
        end
        if (ea > eb) gb = sticky_shr(gb, ea - eb);
        if (sa == sb) begin
            s = ga + gb;
            sign = sa;
        end else if (ga >= gb) begin
            s = ga - gb;
            sign = sa;
        end else begin
            s = gb - ga;
            sign = sb;
        end
        if (s == 0) return 32'd0;
        e = ea + 1;
        while (!s[62]) begin
            s = s << 1;
            e--;
        end
        return round_rne(sign, e, s);
    endfunction

    task automatic predict_item(t_load_item it);
        t_product p;
        logic [31:0] s;
        int k;
        if (it.mode == ModeLoadL || it.mode == ModeLoadR) begin
            if (it.idx < NumElems) begin
                if (it.mode == ModeLoadL) left_mtx[it.idx] = it.bits;
                else right_mtx[it.idx] = it.bits;
            end
        end else if (it.mode == ModeCompute) begin
            for (int r = 0; r < NumRows; r++) begin
                for (int c = 0; c < NumCols; c++) begin
                    k = r * NumCols + c;
                    s = fp_add(fp_mul(left_mtx[r*4], right_mtx[c]),
                               fp_mul(left_mtx[r*4+1], right_mtx[4+c]));
                    s = fp_add(s, fp_mul(left_mtx[r*4+2], right_mtx[8+c]));
                    if (c == 3) s = fp_add(s, left_mtx[r*4+3]);
                    p.idx = IdxW'(k);
                    p.bits = s;
                    p.last = (k == NumElems - 1);
                    expected_products.push_back(p);
                end
            end
        end
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0};
            1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'd0};
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom_range(1, 'h7FFFFF))};
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 23'($urandom)};
            4: return $urandom;
            5: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(240, 254)), 23'($urandom)};
            default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                             8'($urandom_range(110, 144)), 23'($urandom)};
        endcase
    endfunction

    task automatic add_item(logic [1:0] m, logic [IdxW-1:0] ix, logic [31:0] b);
        t_load_item it;
        it.mode = m;
        it.idx = ix;
        it.bits = b;
        pending_items.push_back(it);
    endtask

    task automatic fill_matrices(bit shuffled);
        int order[24];
        int j, t;
        for (int i = 0; i < 24; i++) order[i] = i;
        if (shuffled) begin
            for (int i = 23; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = order[i]; order[i] = order[j]; order[j] = t;
            end
        end
        for (int i = 0; i < 24; i++)
            add_item(order[i] < 12 ? ModeLoadL : ModeLoadR, IdxW'(order[i] % 12), rand_float());
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_load_item it;
                it = pending_items.pop_front();
                predict_item(it);
                i_valid <= 1'b1;
                i_mode <= it.mode;
                i_element_index <= it.idx;
                i_element_bits <= it.bits;
                if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
            hold_off <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_products.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected item idx %0d bits %h",
                                                  o_result_index, o_result_bits);
                end else begin
                    t_product e;
                    e = expected_products.pop_front();
                    if (e.idx !== o_result_index || e.bits !== o_result_bits ||
                        e.last !== o_last_flag) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp idx %0d bits %h last %b, got %0d %h %b",
                                     e.idx, e.bits, e.last, o_result_index,
                                     o_result_bits, o_last_flag);
                    end
                end
            end
            if (hold_req && hold_off == 0) begin
                hold_off <= 600;
                i_stall <= 1'b1;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                hold_off <= hold_req ? hold_off : 0;
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int n;
        mismatches = 0;
        quiet_tail = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode = 0;
        i_element_index = 0;
        i_element_bits = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_off = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, specials, ignored loads and unused mode
        for (int i = 0; i < 12; i++) begin
            add_item(ModeLoadL, IdxW'(i), i == 0 ? 32'h7F80_0000 : i == 1 ? 32'h8000_0000 :
                     i == 2 ? 32'h7FC0_0001 : i == 3 ? 32'hFFFF_FFFF :
                     i == 4 ? 32'h0000_0001 : i == 5 ? 32'h7F7F_FFFF :
                     i == 8 ? 32'h8000_0000 : 32'h3F80_0000);
            add_item(ModeLoadR, IdxW'(i), i == 0 ? 32'h0000_0000 : i == 4 ? 32'h7F80_0001 :
                     i == 1 ? 32'hFF80_0000 : i == 5 ? 32'h7F7F_FFFF :
                     i == 9 ? 32'h7F7F_FFFF : i == 8 ? 32'h8000_0000 :
                     i == 11 ? 32'hFFFF_FFFF : 32'h807F_FFFF);
        end
        add_item(ModeLoadL, 4'd12, 32'h1234_5678);
        add_item(ModeLoadR, 4'd15, 32'hFFFF_FFFF);
        add_item(2'd3, 4'hF, 32'hFFFF_FFFF);
        add_item(ModeCompute, 4'hF, 32'hFFFF_FFFF);
        wait (pending_items.size() == 0 && expected_products.size() == 0);

        // pressure: long receiver hold while loads and computes keep coming
        fill_matrices(0);
        add_item(ModeCompute, 4'd0, 32'd0);
        add_item(ModeLoadL, 4'd0, rand_float());
        add_item(ModeCompute, 4'd0, 32'd0);
        add_item(ModeCompute, 4'd0, 32'd0);
        hold_req = 1;
        repeat (20) @(posedge i_clk);
        hold_req = 0;

        // random: mostly partial reloads then computes, some noise
        n = 0;
        while (n < 230) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_item(2'($urandom_range(0, 3)), 4'($urandom_range(12, 15)), $urandom);
                end
                1, 2: begin
                    add_item(ModeCompute, 4'($urandom), $urandom);
                    n++;
                end
                default: begin
                    add_item($urandom_range(0, 1) ? ModeLoadR : ModeLoadL,
                             4'($urandom_range(0, 11)), rand_float());
                    n++;
                end
            endcase
        end
        add_item(ModeCompute, 4'd0, 32'd0);
        wait (pending_items.size() < 40);
        quiet_tail = 1;
        wait (pending_items.size() == 0 && expected_products.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_products.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: affine_matrix_concat_3x4_top.f
hw/rtl/amc_pkg.sv
hw/rtl/amc_ram.sv
hw/rtl/affine_matrix_concat_3x4_top.sv
hw/rtl/amc_checker.sv
verif/affine_matrix_concat_3x4_top_tb.sv
